[hw/rtl/awsa_pkg.sv]
package awsa_pkg;

	localparam int OFFSET_BITS    = 48;
	localparam int REQUEST_BITS   = 32;
	localparam int DISK_BITS      = 16;
	localparam int DIR_COUNT_BITS = 32;

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_HEADER  = 2'd1,
		OP_LOCAL   = 2'd2,
		OP_CENTRAL = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic CFG_SPLIT_LIMIT = 1'b0;
	localparam logic CFG_SPLIT_NUM   = 1'b1;

	typedef struct packed {
		opcode_t                   opcode;
		logic [REQUEST_BITS-1:0]   byte_count;
		logic [REQUEST_BITS-1:0]   accepted_bytes;
	} req_t;

	typedef struct packed {
		logic [REQUEST_BITS-1:0]   grant;
		logic [REQUEST_BITS-1:0]   written_bytes;
		logic                      write_error;
		logic [OFFSET_BITS-1:0]    entry_bytes;
		logic [OFFSET_BITS-1:0]    split_bytes;
		logic [OFFSET_BITS-1:0]    local_header_offset;
		logic [DISK_BITS-1:0]      local_header_disk;
		logic                      dir_start_set;
		logic [DISK_BITS-1:0]      dir_start_disk;
		logic [OFFSET_BITS-1:0]    dir_start_offset;
		logic [DIR_COUNT_BITS-1:0] dir_entries_disk;
		logic [DIR_COUNT_BITS-1:0] dir_entries_total;
	} res_t;

	function automatic logic [OFFSET_BITS-1:0] sat_add_off(
		input logic [OFFSET_BITS-1:0] a,
		input logic [OFFSET_BITS-1:0] b
	);
		logic [OFFSET_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : sum[OFFSET_BITS-1:0];
	endfunction

	function automatic logic [DIR_COUNT_BITS-1:0] sat_inc_dir(
		input logic [DIR_COUNT_BITS-1:0] a
	);
		return (&a) ? a : a + DIR_COUNT_BITS'(1);
	endfunction

endpackage

[hw/rtl/archive_write_split_accounting.sv]
// Archive write split accounting.
//
// Channels: in (valid/ready, req_t) carries one write request per transfer:
// kind, requested byte count and the byte count the sink took. out
// (valid/ready, res_t) returns one result per request: the grant under the
// split limit, the bytes counted, a shortfall flag and the running entry,
// split, local header and central directory bookkeeping. cfg (valid/ready,
// always ready) writes split_limit (index 0) and the split number (index 1);
// write it only while no request is in flight.
//
// Timing: a request is registered in the input stage, where the grant and
// the counter updates are worked out against the counter registers, and
// then moves into the output register once that register is free or drains.
// One request per cycle is sustained while out_ready holds; the rate is
// set by the single compare/add path from the input stage to the counters.
//
// Reset clears all counters, the directory start flag and both config
// registers (split limit zero means no limit). When the receiver stalls, the
// result holds in the output register, one more request waits in the input
// stage, and in_ready drops until the output drains.
module archive_write_split_accounting
	import awsa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  req_t                   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output res_t                   out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [OFFSET_BITS-1:0] cfg_data
);

	// config
	logic [OFFSET_BITS-1:0]    split_limit_q;
	logic [DISK_BITS-1:0]      split_num_q;

	// accounting state
	logic [OFFSET_BITS-1:0]    entry_q;
	logic [OFFSET_BITS-1:0]    split_q;
	logic [OFFSET_BITS-1:0]    local_off_q;
	logic [DISK_BITS-1:0]      local_disk_q;
	logic                      dir_rec_q;
	logic [DISK_BITS-1:0]      dir_disk_q;
	logic [OFFSET_BITS-1:0]    dir_off_q;
	logic [DIR_COUNT_BITS-1:0] dir_disk_cnt_q;
	logic [DIR_COUNT_BITS-1:0] dir_total_q;

	// input stage and output register
	logic                      valid_s1;
	req_t                      req_s1;
	logic                      out_valid_q;
	res_t                      out_data_q;

	logic                      advance;

	// next-state values for the request in the input stage
	logic [OFFSET_BITS-1:0]    req_wide;
	logic [OFFSET_BITS-1:0]    room;
	logic                      over_limit;
	logic                      fits;
	logic [REQUEST_BITS-1:0]   grant;
	logic [REQUEST_BITS-1:0]   written;
	logic [OFFSET_BITS-1:0]    entry_d;
	logic [OFFSET_BITS-1:0]    split_d;
	logic [OFFSET_BITS-1:0]    local_off_d;
	logic [DISK_BITS-1:0]      local_disk_d;
	logic                      dir_rec_d;
	logic [DISK_BITS-1:0]      dir_disk_d;
	logic [OFFSET_BITS-1:0]    dir_off_d;
	logic [DIR_COUNT_BITS-1:0] dir_disk_cnt_d;
	logic [DIR_COUNT_BITS-1:0] dir_total_d;
	res_t                      res_d;

	// The input stage moves on whenever the output register is free or drains.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		req_wide   = OFFSET_BITS'(req_s1.byte_count);
		room       = split_limit_q - split_q;
		over_limit = split_q >= split_limit_q;
		fits       = (split_limit_q == '0) || (!over_limit && req_wide <= room);

		// Headers go all or nothing; data takes what is left of the split.
		// When data does not fit, room is below the request, so it fits the width.
		if (fits) begin
			grant = req_s1.byte_count;
		end else if (req_s1.opcode == OP_DATA && !over_limit) begin
			grant = room[REQUEST_BITS-1:0];
		end else begin
			grant = '0;
		end

		written = (req_s1.accepted_bytes < grant) ? req_s1.accepted_bytes : grant;
		split_d = sat_add_off(split_q, OFFSET_BITS'(written));

		entry_d        = entry_q;
		local_off_d    = local_off_q;
		local_disk_d   = local_disk_q;
		dir_rec_d      = dir_rec_q;
		dir_disk_d     = dir_disk_q;
		dir_off_d      = dir_off_q;
		dir_disk_cnt_d = dir_disk_cnt_q;
		dir_total_d    = dir_total_q;

		case (req_s1.opcode)
			OP_DATA: begin
				entry_d = sat_add_off(entry_q, OFFSET_BITS'(written));
			end
			OP_LOCAL: begin
				// local header starts a new entry where the split stands now
				entry_d      = '0;
				local_off_d  = split_q;
				local_disk_d = split_num_q;
			end
			OP_CENTRAL: begin
				// first central header marks the directory start
				if (!dir_rec_q) begin
					dir_rec_d  = 1'b1;
					dir_disk_d = split_num_q;
					dir_off_d  = split_q;
				end
				dir_disk_cnt_d = sat_inc_dir(dir_disk_cnt_q);
				dir_total_d    = sat_inc_dir(dir_total_q);
			end
			default: begin
			end
		endcase

		res_d.grant               = grant;
		res_d.written_bytes       = written;
		res_d.write_error         = written < req_s1.byte_count;
		res_d.entry_bytes         = entry_d;
		res_d.split_bytes         = split_d;
		res_d.local_header_offset = local_off_d;
		res_d.local_header_disk   = local_disk_d;
		res_d.dir_start_set       = dir_rec_d;
		res_d.dir_start_disk      = dir_disk_d;
		res_d.dir_start_offset    = dir_off_d;
		res_d.dir_entries_disk    = dir_disk_cnt_d;
		res_d.dir_entries_total   = dir_total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_limit_q <= '0;
			split_num_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPLIT_LIMIT: split_limit_q <= cfg_data;
				CFG_SPLIT_NUM:   split_num_q   <= cfg_data[DISK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q        <= '0;
			split_q        <= '0;
			local_off_q    <= '0;
			local_disk_q   <= '0;
			dir_rec_q      <= 1'b0;
			dir_disk_q     <= '0;
			dir_off_q      <= '0;
			dir_disk_cnt_q <= '0;
			dir_total_q    <= '0;
		end else if (advance) begin
			entry_q        <= entry_d;
			split_q        <= split_d;
			local_off_q    <= local_off_d;
			local_disk_q   <= local_disk_d;
			dir_rec_q      <= dir_rec_d;
			dir_disk_q     <= dir_disk_d;
			dir_off_q      <= dir_off_d;
			dir_disk_cnt_q <= dir_disk_cnt_d;
			dir_total_q    <= dir_total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res_d;
		end
	end

	// once recorded, the directory start stays recorded
	a_dir_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dir_rec_q |=> dir_rec_q)
		else $error("directory start flag cleared");

	// split byte count never goes back
	a_split_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> split_q >= $past(split_q))
		else $error("split byte count decreased");

	// input side stalls only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without output backpressure");

	// counted bytes never exceed the grant
	a_written_le_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.written_bytes <= out_data_q.grant)
		else $error("bytes written above grant");

endmodule
